>>> src/hsi_pkg.sv
// Shared constants and controller/datapath interface types for the Hermite spline interpolator.
package hsi_pkg;

  localparam int PT_W            = 32;     // control point coordinate, Q16.16
  localparam int TAG_W           = 16;
  localparam int STEPS_W         = 6;
  localparam int TSTEP_W         = 16;
  localparam int TDATA_W         = 3 * PT_W + TAG_W;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  localparam int MAX_STEPS_DEF   = 32;
  localparam int COORD_WIDTH_DEF = 32;

  localparam logic [STEPS_W-1:0] STEPS_RESET     = 6'd9;
  localparam logic [TSTEP_W-1:0] TIME_STEP_RESET = 16'd7282;

  // 0.8 in Q0.16
  localparam int TANGENT_GAIN = 52429;
  // 1.0 in Q0.16, upper bound of the curve parameter
  localparam int T_ONE        = 65536;

  localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'd1;

  typedef struct packed {
    logic load;      // take the input beat into the work registers
    logic tan_mul;   // multiply the tangent difference by the gain
    logic tan_sat;   // round and saturate the end tangent
    logic issue;     // push one curve point into the pipeline
    logic seg;       // 0: earlier-recent segment, 1: recent-new segment
    logic tag_end;   // point lies in the second half of the segment
    logic seg_end;   // last point of the segment
    logic last;      // last point caused by this beat
  } hsi_cmd_t;

  typedef struct packed {
    logic       adv;         // pipeline moves this cycle
    logic       front_busy;  // points still need the work registers
    logic [1:0] seen;        // points held when the beat was taken
    logic       fin;         // beat was the final point of a path
  } hsi_sts_t;

endpackage

>>> src/hsi_ctrl.sv
// Sequencer: tangent phases and per-segment point issue for the Hermite spline interpolator.
module hsi_ctrl #(
  parameter int MAX_STEPS = hsi_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsi_pkg::STEPS_W-1:0] steps,
  output hsi_pkg::hsi_cmd_t           cmd,
  input  hsi_pkg::hsi_sts_t           sts
);
  import hsi_pkg::*;

  localparam int KW = $clog2(MAX_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_TAN_MUL = 4'b0010,
    ST_TAN_SAT = 4'b0100,
    ST_SEG     = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [KW-1:0] k, k_next;
  logic          seg, seg_next;
  logic [KW-1:0] n;
  logic          k_last;
  logic          two_segs;
  logic          has_pair;

  always_comb begin
    if (steps == '0) begin
      n = KW'(1);
    end else if (int'(steps) > MAX_STEPS) begin
      n = KW'(MAX_STEPS);
    end else begin
      n = KW'(steps);
    end
  end

  assign k_last   = (k == n - KW'(1));
  assign has_pair = (sts.seen == 2'd2);
  assign two_segs = sts.fin && (sts.seen != 2'd0);

  assign in_ready     = (state == ST_IDLE) && !sts.front_busy;
  assign cmd.load     = in_valid && in_ready;
  assign cmd.tan_mul  = (state == ST_TAN_MUL);
  assign cmd.tan_sat  = (state == ST_TAN_SAT);
  assign cmd.issue    = (state == ST_SEG);
  assign cmd.seg      = seg;
  assign cmd.tag_end  = (k > (n >> 1));
  assign cmd.seg_end  = k_last;
  assign cmd.last     = k_last && (seg || !two_segs);

  always_comb begin
    state_next = state;
    k_next     = k;
    seg_next   = seg;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_TAN_MUL;
      end
      ST_TAN_MUL: begin
        state_next = ST_TAN_SAT;
      end
      ST_TAN_SAT: begin
        k_next   = '0;
        seg_next = !has_pair;
        // a second point that is not final only gets stored
        state_next = (has_pair || two_segs) ? ST_SEG : ST_IDLE;
      end
      ST_SEG: begin
        if (sts.adv) begin
          if (k_last) begin
            if (!seg && two_segs) begin
              seg_next = 1'b1;
              k_next   = '0;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            k_next = k + KW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      seg   <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      seg   <= seg_next;
    end
  end

endmodule

>>> src/hsi_datapath.sv
// Point history, tangent unit and the pipelined Hermite basis and blend for the interpolator.
module hsi_datapath #(
  parameter int MAX_STEPS   = hsi_pkg::MAX_STEPS_DEF,
  parameter int COORD_WIDTH = hsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hsi_pkg::hsi_cmd_t                  cmd,
  output hsi_pkg::hsi_sts_t                  sts,
  input  logic signed [hsi_pkg::PT_W-1:0]    px,
  input  logic signed [hsi_pkg::PT_W-1:0]    py,
  input  logic signed [hsi_pkg::PT_W-1:0]    pz,
  input  logic        [hsi_pkg::TAG_W-1:0]   tag,
  input  logic                               final_point,
  input  logic        [hsi_pkg::TSTEP_W-1:0] time_step,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hsi_pkg::PT_W-1:0]    qx,
  output logic signed [hsi_pkg::PT_W-1:0]    qy,
  output logic signed [hsi_pkg::PT_W-1:0]    qz,
  output logic        [hsi_pkg::TAG_W-1:0]   owner_tag,
  output logic                               run_end
);
  import hsi_pkg::*;

  localparam int TACC_W  = $clog2(MAX_STEPS + 1) + TSTEP_W;
  localparam int TP_W    = 17;                       // t in Q0.16, up to 1.0
  localparam int SQ_W    = 2 * TP_W - 1;             // t^2, up to 2^32
  localparam int CU_W    = 49;                       // t^3, up to 2^48
  localparam int BX_W    = 52;                       // basis before rounding, Q.48
  localparam int H_W     = 32;                       // basis after rounding, Q.30
  localparam int DIFF_W  = PT_W + 1;
  localparam int GAIN_W  = 18;
  localparam int TPROD_W = DIFF_W + GAIN_W;
  localparam int TR_W    = TPROD_W - 16;
  localparam int XW      = (COORD_WIDTH > PT_W) ? COORD_WIDTH : PT_W;
  localparam int PROD_W  = H_W + XW;
  localparam int PS_W    = PROD_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RND_W   = ACC_W - 30;

  localparam logic signed [GAIN_W-1:0] GAIN   = GAIN_W'(TANGENT_GAIN);
  localparam logic signed [BX_W-1:0]   BX_ONE = BX_W'(1) <<< 48;
  localparam logic signed [BX_W-1:0]   BX_RND = BX_W'(1) <<< 17;
  localparam logic signed [H_W-1:0]    H_ONE  = H_W'(1) <<< 30;
  localparam logic signed [63:0]       CMAX   = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0]       CMIN   = -CMAX - 64'sd1;

  typedef struct packed {
    logic             seg;
    logic [TAG_W-1:0] tag;
    logic             last;
  } meta_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_cw(input logic signed [63:0] v);
    if (v > CMAX) return COORD_WIDTH'(CMAX);
    if (v < CMIN) return COORD_WIDTH'(CMIN);
    return COORD_WIDTH'(v);
  endfunction

  logic signed [PT_W-1:0] pin [3];
  assign pin[0] = px;
  assign pin[1] = py;
  assign pin[2] = pz;

  // path history
  logic signed [PT_W-1:0]        rp [3];
  logic signed [PT_W-1:0]        ep [3];
  logic signed [COORD_WIDTH-1:0] et [3];
  logic [TAG_W-1:0]              rtag, etag;
  logic [1:0]                    seen;

  // work registers for the beat in progress
  logic signed [PT_W-1:0]        wa [3];
  logic signed [PT_W-1:0]        wb [3];
  logic signed [PT_W-1:0]        wp [3];
  logic signed [COORD_WIDTH-1:0] wta [3];
  logic signed [COORD_WIDTH-1:0] wtb [3];
  logic [TAG_W-1:0]              wtag_a, wtag_b, wtag_p;
  logic [1:0]                    wseen;
  logic                          wfin;
  logic signed [DIFF_W-1:0]      diff [3];
  logic signed [TPROD_W-1:0]     tprod [3];
  logic signed [TR_W-1:0]        trnd [3];
  logic signed [COORD_WIDTH-1:0] tnew [3];

  logic adv;
  assign adv = !out_valid || out_ready;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trnd[c] = TR_W'((tprod[c] + TPROD_W'(32768)) >>> 16);
      tnew[c] = (wseen == 2'd2) ? sat_cw(64'(trnd[c])) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < 3; c++) begin
        wa[c]   <= ep[c];
        wb[c]   <= rp[c];
        wta[c]  <= et[c];
        wp[c]   <= pin[c];
        diff[c] <= DIFF_W'(pin[c]) - DIFF_W'(ep[c]);
      end
      wtag_a <= etag;
      wtag_b <= rtag;
      wtag_p <= tag;
      wseen  <= seen;
      wfin   <= final_point;
      if (!final_point) begin
        if (seen != 2'd0) begin
          for (int c = 0; c < 3; c++) ep[c] <= rp[c];
          etag <= rtag;
        end
        for (int c = 0; c < 3; c++) rp[c] <= pin[c];
        rtag <= tag;
      end
    end
    if (cmd.tan_mul) begin
      for (int c = 0; c < 3; c++) tprod[c] <= diff[c] * GAIN;
    end
    if (cmd.tan_sat) begin
      for (int c = 0; c < 3; c++) begin
        wtb[c] <= tnew[c];
        if (!wfin && wseen != 2'd0) et[c] <= tnew[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 2'd0;
    end else if (cmd.load) begin
      if (final_point) begin
        seen <= 2'd0;
      end else if (seen != 2'd2) begin
        seen <= seen + 2'd1;
      end
    end
  end

  // curve parameter, back to zero at every segment end
  logic [TACC_W-1:0] t_acc;
  logic [TP_W-1:0]   t_cur;

  assign t_cur = (t_acc > TACC_W'(T_ONE)) ? TP_W'(T_ONE) : t_acc[TP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_acc <= '0;
    end else if (cmd.issue && adv) begin
      t_acc <= cmd.seg_end ? '0 : t_acc + TACC_W'(time_step);
    end
  end

  // pipeline: t, t^2, t^3, basis, products, pair sums, sum, round/saturate
  logic v1, v2, v3, v4, v5, v6, v7;
  meta_t m1, m2, m3, m4, m5, m6, m7;
  meta_t m_issue;

  logic [TP_W-1:0] t1, t2, t3;
  logic [SQ_W-1:0] sq2, sq3;
  logic [CU_W-1:0] cu3;
  logic signed [H_W-1:0]    h4 [4];
  logic signed [PROD_W-1:0] pr [3][4];
  logic signed [PS_W-1:0]   ps [3][2];
  logic signed [ACC_W-1:0]  acc [3];

  logic signed [BX_W-1:0] t_s, sq_s, cu_s, x1, x3, x4;
  logic signed [XW-1:0]   oa [3];
  logic signed [XW-1:0]   ob [3];
  logic signed [XW-1:0]   ota [3];
  logic signed [XW-1:0]   otb [3];
  logic signed [RND_W-1:0]       rnd [3];
  logic signed [COORD_WIDTH-1:0] qsat [3];
  logic signed [XW-1:0]          qext [3];

  always_comb begin
    m_issue.seg  = cmd.seg;
    m_issue.last = cmd.last;
    if (cmd.seg) begin
      m_issue.tag = cmd.tag_end ? wtag_p : wtag_b;
    end else begin
      m_issue.tag = cmd.tag_end ? wtag_b : wtag_a;
    end
  end

  always_comb begin
    t_s  = signed'(BX_W'(t3));
    sq_s = signed'(BX_W'(sq3));
    cu_s = signed'(BX_W'(cu3));
    x1   = (cu_s <<< 1) - (sq_s <<< 16) - (sq_s <<< 17) + BX_ONE;
    x3   = cu_s - (sq_s <<< 17) + (t_s <<< 32);
    x4   = cu_s - (sq_s <<< 16);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      oa[c]  = m4.seg ? XW'(wb[c])  : XW'(wa[c]);
      ob[c]  = m4.seg ? XW'(wp[c])  : XW'(wb[c]);
      ota[c] = m4.seg ? XW'(wtb[c]) : XW'(wta[c]);
      otb[c] = m4.seg ? '0          : XW'(wtb[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c]  = RND_W'((acc[c] + ACC_W'(1 <<< 29)) >>> 30);
      qsat[c] = sat_cw(64'(rnd[c]));
      qext[c] = XW'(qsat[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= cmd.issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1  <= t_cur;
      m1  <= m_issue;

      t2  <= t1;
      sq2 <= t1 * t1;
      m2  <= m1;

      t3  <= t2;
      sq3 <= sq2;
      cu3 <= sq2 * t2;
      m3  <= m2;

      h4[0] <= H_W'((x1 + BX_RND) >>> 18);
      h4[1] <= H_ONE - H_W'((x1 + BX_RND) >>> 18);
      h4[2] <= H_W'((x3 + BX_RND) >>> 18);
      h4[3] <= H_W'((x4 + BX_RND) >>> 18);
      m4    <= m3;

      for (int c = 0; c < 3; c++) begin
        pr[c][0] <= h4[0] * oa[c];
        pr[c][1] <= h4[1] * ob[c];
        pr[c][2] <= h4[2] * ota[c];
        pr[c][3] <= h4[3] * otb[c];
      end
      m5 <= m4;

      for (int c = 0; c < 3; c++) begin
        ps[c][0] <= PS_W'(pr[c][0]) + PS_W'(pr[c][1]);
        ps[c][1] <= PS_W'(pr[c][2]) + PS_W'(pr[c][3]);
      end
      m6 <= m5;

      for (int c = 0; c < 3; c++) begin
        acc[c] <= ACC_W'(ps[c][0]) + ACC_W'(ps[c][1]);
      end
      m7 <= m6;

      qx        <= qext[0][PT_W-1:0];
      qy        <= qext[1][PT_W-1:0];
      qz        <= qext[2][PT_W-1:0];
      owner_tag <= m7.tag;
      run_end   <= m7.last;
    end
  end

  assign sts.adv        = adv;
  assign sts.front_busy = v1 | v2 | v3 | v4;
  assign sts.seen       = wseen;
  assign sts.fin        = wfin;

endmodule

>>> src/hermite_spline_interpolator_unit.sv
// Top level of the cubic Hermite spline interpolator: configuration registers and stream ports.
//
// Control points stream in on the s_axis side and curve points leave on the m_axis side,
// coordinates in signed Q16.16. Inner points get the tangent 0.8*(next - previous), the ends of a
// path get zero tangents; once a segment's end tangent is known, steps points are emitted along it
// at t = k*time_step (t held at 1.0), with the start tag for k <= steps/2 and the end tag beyond.
// tlast on input marks the final point of a path, which flushes the last segment and clears the
// history; tlast on output marks the last point caused by that input beat. A beat that emits
// nothing (first or second point of a path) only runs the tangent multiply and saturate states. A
// beat that emits then issues one curve point per cycle while m_axis is not stalled (steps, or
// 2*steps for a final point with two points held), and the last point must clear the t, t^2, t^3
// and basis stages before the next beat may reload the work registers; a stalled m_axis holds the
// whole point pipeline.
// Write steps and time_step only while the block is idle.
module hermite_spline_interpolator_unit #(
  parameter int MAX_STEPS   = hsi_pkg::MAX_STEPS_DEF,
  parameter int COORD_WIDTH = hsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hsi_pkg::TDATA_W-1:0]      s_axis_tdata,   // px, py, pz, tag
  input  logic                             s_axis_tlast,   // final_point
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hsi_pkg::TDATA_W-1:0]      m_axis_tdata,   // qx, qy, qz, owner_tag
  output logic                             m_axis_tlast,   // run_end
  input  logic                             cfg_we,
  input  logic [hsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hsi_pkg::*;

  logic [STEPS_W-1:0] steps;
  logic [TSTEP_W-1:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps     <= STEPS_RESET;
      time_step <= TIME_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEPS:     steps     <= cfg_data[STEPS_W-1:0];
        REG_TIME_STEP: time_step <= cfg_data[TSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  hsi_cmd_t cmd;
  hsi_sts_t sts;

  logic signed [PT_W-1:0] qx, qy, qz;
  logic [TAG_W-1:0]       owner_tag;

  hsi_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .steps    (steps),
    .cmd      (cmd),
    .sts      (sts)
  );

  hsi_datapath #(
    .MAX_STEPS   (MAX_STEPS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .px          (s_axis_tdata[PT_W-1:0]),
    .py          (s_axis_tdata[2*PT_W-1:PT_W]),
    .pz          (s_axis_tdata[3*PT_W-1:2*PT_W]),
    .tag         (s_axis_tdata[3*PT_W+TAG_W-1:3*PT_W]),
    .final_point (s_axis_tlast),
    .time_step   (time_step),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .qx          (qx),
    .qy          (qy),
    .qz          (qz),
    .owner_tag   (owner_tag),
    .run_end     (m_axis_tlast)
  );

  assign m_axis_tdata = {owner_tag, qz, qy, qx};

endmodule

>>> tb/sv/hermite_spline_interpolator_unit_tb.sv
// Self-checking testbench for the Hermite spline interpolator: directed table and random paths.
`timescale 1ns / 1ps

module hermite_spline_interpolator_unit_tb;
  import hsi_pkg::*;

  localparam longint Q_MAX = (64'sd1 <<< (COORD_WIDTH_DEF - 1)) - 1;
  localparam longint Q_MIN = -Q_MAX - 1;
  localparam int     N_PHASES = 8;
  localparam int     PHASE_PTS = 18;
  localparam int     SETTLE_CYCLES = 20;

  typedef logic [2:0][63:0] vec3_t;

  typedef struct packed {
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
    logic [15:0] owner;
    logic        run_end;
  } curve_pt_t;

  // lit_n >= 0: flat segment whose results are typed in, all at the row's own point
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] tag;
    logic        fin;
    int          lit_n;
    logic [15:0] lit_tag_a;
  } dir_row_t;

  localparam int N_ROWS = 15;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'hFFFF, 1'b1, 0, 16'h0000},
    '{32'h1234_5678, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 16'h00A5, 1'b0, 0, 16'h0000},
    '{32'h1234_5678, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 16'h5A00, 1'b1, 9, 16'h00A5},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0, 0, 16'h0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 0, 16'h0000},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h1234, 1'b0, -1, 16'h0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h4321, 1'b1, -1, 16'h0000},
    '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 16'h0001, 1'b0, -1, 16'h0000},
    '{32'h0005_0000, 32'h0003_0000, 32'hFFF0_0000, 16'h0002, 1'b0, -1, 16'h0000},
    '{32'h000A_8000, 32'hFFFE_0000, 32'h0000_1234, 16'h0003, 1'b0, -1, 16'h0000},
    '{32'h0003_0000, 32'h0000_0001, 32'h0010_0000, 16'h0004, 1'b0, -1, 16'h0000},
    '{32'h0000_0000, 32'h0004_0000, 32'hFFFF_FFFF, 16'h0005, 1'b1, -1, 16'h0000},
    '{32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 16'h0006, 1'b0, -1, 16'h0000},
    '{32'hFFF0_0000, 32'h0008_0000, 32'h7FFF_0000, 16'h0007, 1'b1, -1, 16'h0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0008, 1'b1, 0, 16'h0000}
  };

  // settings per random phase: out-of-range steps and both time_step extremes included
  localparam int PH_STEPS [N_PHASES] = '{1, 32, 0, 63, 5, 2, 17, 9};
  localparam int PH_TSTEP [N_PHASES] = '{65535, 2048, 0, 65535, 13107, 40000, 3855, 7282};

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata;    // px, py, pz, tag
  logic                   s_axis_tlast;    // final_point
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_W-1:0]     m_axis_tdata;    // qx, qy, qz, owner_tag
  logic                   m_axis_tlast;    // run_end
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor state and register mirror
  vec3_t          pt_recent;
  vec3_t          pt_earlier;
  vec3_t          tan_earlier;
  logic [15:0]    tag_recent;
  logic [15:0]    tag_earlier;
  int             pts_held;
  logic [5:0]     cur_steps;
  logic [15:0]    cur_tstep;

  curve_pt_t      pending_curve_pts [$];
  int unsigned    mismatch_count;
  int             busy_pct;

  hermite_spline_interpolator_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint shr_round(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // append one expected curve point to the scoreboard
  task automatic queue_curve_pt(input curve_pt_t q);
    pending_curve_pts = {pending_curve_pts, q};
  endtask

  // queue steps points along a - b with Hermite basis weights
  task automatic trace_segment(input vec3_t a, input vec3_t b, input vec3_t ta,
                               input vec3_t tb, input logic [15:0] tag_s,
                               input logic [15:0] tag_e);
    int        n;
    longint    t, t2, t3, h1, h2, h3, h4, acc;
    longint    av, bv, tav, tbv;
    curve_pt_t q;
    logic [31:0] co [3];
    n = (cur_steps == 0) ? 1 : (cur_steps > MAX_STEPS_DEF) ? MAX_STEPS_DEF : int'(cur_steps);
    for (int k = 0; k < n; k++) begin
      t = longint'(k) * longint'(cur_tstep);
      if (t > T_ONE) t = T_ONE;
      t2 = t * t;
      t3 = t2 * t;
      h1 = shr_round(2 * t3 - 3 * (t2 * 65536) + (64'sd1 <<< 48), 18);
      h2 = (64'sd1 <<< 30) - h1;
      h3 = shr_round(t3 - 2 * (t2 * 65536) + t * (64'sd1 <<< 32), 18);
      h4 = shr_round(t3 - t2 * 65536, 18);
      for (int c = 0; c < 3; c++) begin
        av  = a[c];
        bv  = b[c];
        tav = ta[c];
        tbv = tb[c];
        acc = h1 * av + h2 * bv + h3 * tav + h4 * tbv;
        co[c] = 32'(clamp_q(shr_round(acc, 30)));
      end
      q.qx      = co[0];
      q.qy      = co[1];
      q.qz      = co[2];
      q.owner   = (k <= n / 2) ? tag_s : tag_e;
      q.run_end = 1'b0;
      queue_curve_pt(q);
    end
  endtask

  task automatic predict_control_point(input logic [31:0] px, input logic [31:0] py,
                                       input logic [31:0] pz, input logic [15:0] tag,
                                       input logic fin);
    vec3_t  p, tb, zero_v;
    longint d;
    int     before_n;
    before_n = pending_curve_pts.size();
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    tb = '0;
    zero_v = '0;
    if (pts_held >= 2) begin
      for (int c = 0; c < 3; c++) begin
        d = p[c] - pt_earlier[c];
        tb[c] = clamp_q(shr_round(d * TANGENT_GAIN, 16));
      end
      trace_segment(pt_earlier, pt_recent, tan_earlier, tb, tag_earlier, tag_recent);
    end
    if (fin) begin
      if (pts_held >= 1) trace_segment(pt_recent, p, tb, zero_v, tag_recent, tag);
      pt_recent   = '0;
      pt_earlier  = '0;
      tan_earlier = '0;
      tag_recent  = '0;
      tag_earlier = '0;
      pts_held    = 0;
    end else begin
      if (pts_held >= 1) begin
        pt_earlier  = pt_recent;
        tan_earlier = tb;
        tag_earlier = tag_recent;
      end
      pt_recent  = p;
      tag_recent = tag;
      if (pts_held < 2) pts_held++;
    end
    if (pending_curve_pts.size() > before_n)
      pending_curve_pts[pending_curve_pts.size() - 1].run_end = 1'b1;
  endtask

  // present one control point, hold it until taken, then predict its curve points
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic [15:0] tag, input logic fin, input int lit_n,
                            input logic [15:0] lit_tag_a);
    int        before_n;
    curve_pt_t q;
    while ($urandom_range(99) < busy_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, z, y, x};
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    before_n = pending_curve_pts.size();
    predict_control_point(x, y, z, tag, fin);
    if (lit_n >= 0) begin
      // replace with the typed-in results
      while (pending_curve_pts.size() > before_n) void'(pending_curve_pts.pop_back());
      for (int k = 0; k < lit_n; k++) begin
        q.qx      = x;
        q.qy      = y;
        q.qz      = z;
        q.owner   = (k <= lit_n / 2) ? lit_tag_a : tag;
        q.run_end = (k == lit_n - 1);
        queue_curve_pt(q);
      end
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_curve_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [5:0] steps_val, input logic [15:0] tstep_val);
    logic [9:0] junk;
    junk = 10'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEPS;
    cfg_data  <= {junk, steps_val};
    @(posedge clk);
    cfg_index <= REG_TIME_STEP;
    cfg_data  <= tstep_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_steps = steps_val;
    cur_tstep = tstep_val;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9)) inside
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      [2:3]:   return $urandom;
      default: return $urandom_range(13107200) - 32'd6553600;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin : take_beat
        curve_pt_t got;
        curve_pt_t want;
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tdata[111:96], m_axis_tlast};
        if (pending_curve_pts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: curve point with nothing pending: %h %h %h tag %h last %b",
                     $time, got.qx, got.qy, got.qz, got.owner, got.run_end);
        end else begin
          want = pending_curve_pts.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: exp %h %h %h tag %h last %b, got %h %h %h tag %h last %b",
                       $time, want.qx, want.qy, want.qz, want.owner, want.run_end,
                       got.qx, got.qy, got.qz, got.owner, got.run_end);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= busy_pct);
    end
  end

  initial begin
    int remaining;
    int len;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_STEPS;
    cfg_data       = '0;
    busy_pct       = 37;
    mismatch_count = 0;
    pt_recent      = '0;
    pt_earlier     = '0;
    tan_earlier    = '0;
    tag_recent     = '0;
    tag_earlier    = '0;
    pts_held       = 0;
    cur_steps      = STEPS_RESET;
    cur_tstep      = TIME_STEP_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_ROWS; r++)
      send_point(DIR_ROWS[r].x, DIR_ROWS[r].y, DIR_ROWS[r].z, DIR_ROWS[r].tag,
                 DIR_ROWS[r].fin, DIR_ROWS[r].lit_n, DIR_ROWS[r].lit_tag_a);
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_settings(6'(PH_STEPS[ph]), 16'(PH_TSTEP[ph]));
      // one phase runs flat out on both sides
      busy_pct = (ph == 6) ? 0 : 37;
      remaining = PHASE_PTS;
      while (remaining > 0) begin
        len = $urandom_range(1, 6);
        if (len > remaining) len = remaining;
        for (int i = 0; i < len; i++)
          send_point(rand_coord(), rand_coord(), rand_coord(), 16'($urandom_range(65535)),
                     (i == len - 1), -1, 16'h0000);
        remaining -= len;
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("hermite_spline_interpolator_unit_tb OK");
    end else begin
      $display("hermite_spline_interpolator_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("hermite_spline_interpolator_unit_tb NOT OK");
    $finish;
  end

endmodule
